// ===== rtl/qses_pkg.sv =====
`default_nettype none
package qses_pkg;

   localparam int MAX_SERVERS_DEF = 8;
   localparam int CUSTOMERS_DEF   = 4096;
   localparam int QUEUE_DEPTH_DEF = 1024;

   localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      OP_ARRIVE = 3'd0,
      OP_DEPART = 3'd1,
      OP_FAIL   = 3'd2,
      OP_REPAIR = 3'd3,
      OP_REPORT = 3'd4
   } op_type;

   localparam logic [2:0] KIND_ARRIVE = 3'd0;
   localparam logic [2:0] KIND_DEPART = 3'd1;
   localparam logic [2:0] KIND_FAIL   = 3'd2;
   localparam logic [2:0] KIND_REPAIR = 3'd3;
   localparam logic [2:0] KIND_STAT   = 3'd4;

   typedef enum logic [1:0] {
      SRV_IDLE = 2'd0,
      SRV_BUSY = 2'd1,
      SRV_DOWN = 2'd2
   } srv_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RD   = 2'd1,
      ST_EXEC = 2'd2
   } fsm_type;

   localparam logic [2:0] REG_SERVER_COUNT = 3'd0;
   localparam logic [2:0] REG_QUEUE_LIMIT  = 3'd1;
   localparam logic [2:0] REG_FAILURE_EN   = 3'd2;
   localparam logic [2:0] REG_ARRIVAL_QUOTA = 3'd3;
   localparam logic [2:0] REG_WARMUP_COUNT = 3'd4;

   localparam logic [11:0] STAT_DEPARTURES = 12'd0;
   localparam logic [11:0] STAT_HORIZON    = 12'd1;
   localparam logic [11:0] STAT_AREA_SYS   = 12'd2;
   localparam logic [11:0] STAT_AREA_QUEUE = 12'd3;
   localparam logic [11:0] STAT_AREA_BUSY  = 12'd4;
   localparam logic [11:0] STAT_AREA_DOWN  = 12'd5;
   localparam logic [11:0] STAT_WAIT       = 12'd6;
   localparam logic [11:0] STAT_SOJOURN    = 12'd7;
   localparam logic [11:0] STAT_MEASURED   = 12'd8;
   localparam logic [11:0] STAT_DROPS      = 12'd9;
   localparam logic [11:0] STAT_EMITTED    = 12'd10;
   localparam logic [11:0] STAT_OCCUPANCY  = 12'd11;
   localparam logic [11:0] STAT_QUEUED     = 12'd12;
   localparam logic [11:0] STAT_BUSY       = 12'd13;
   localparam logic [11:0] STAT_DOWN       = 12'd14;

   typedef struct packed {
      logic [2:0]  op;
      logic [47:0] event_time;
      logic [11:0] tag;
      logic [39:0] gap_time;
      logic [39:0] service_time;
      logic [39:0] failure_time;
      logic [39:0] repair_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [62:0] value;
      logic [11:0] target;
      logic        last;
   } rsp_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      if (a > SAT63 || b > SAT63 - a) return SAT63;
      return a + b;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/queue_server_event_step_top.sv =====
`default_nettype none
// flow: a request is registered on acceptance, read in the RD state and executed in
// the EXEC state, and its results are registered into the result buffer; a new
// request is taken in EXEC but not in RD, set by the memory read then write-back
// of the queue and stamp memories; a request waits while earlier results are pending
// reset: synchronous active high, clears servers, queue pointers, counters and sums;
// queue and stamp memories are not cleared
module queue_server_event_step_top #(
   parameter int MAX_SERVERS = qses_pkg::MAX_SERVERS_DEF,
   parameter int CUSTOMERS   = qses_pkg::CUSTOMERS_DEF,
   parameter int QUEUE_DEPTH = qses_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire qses_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output qses_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [4:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import qses_pkg::*;

   localparam int QSLOTS = QUEUE_DEPTH + MAX_SERVERS;
   localparam int QAW    = $clog2(QSLOTS);
   localparam int QCW    = $clog2(QSLOTS + 1);
   localparam int CAW    = $clog2(CUSTOMERS);
   localparam int SW     = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

   function automatic logic [CAW-1:0] caddr(input logic [11:0] id);
      logic [31:0] w;
      w = 32'(id);
      return w[CAW-1:0];
   endfunction

   function automatic rsp_type put(input logic [2:0] kind, input logic [62:0] v,
                                   input logic [11:0] t);
      rsp_type r;
      r.result_kind = kind;
      r.value       = v;
      r.target      = t;
      r.last        = 1'b0;
      return r;
   endfunction

   // configuration registers
   logic [3:0]  cfg_sc_ff;
   logic [10:0] cfg_ql_ff;
   logic        cfg_fe_ff;
   logic [12:0] cfg_aq_ff;
   logic [12:0] cfg_wu_ff;

   logic csr_write;
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sc_ff <= 4'd1;
         cfg_ql_ff <= 11'd1024;
         cfg_fe_ff <= 1'b0;
         cfg_aq_ff <= 13'd4096;
         cfg_wu_ff <= 13'd0;
      end else if (csr_write) begin
         case (paddr[4:2])
            REG_SERVER_COUNT:  cfg_sc_ff <= pwdata[3:0];
            REG_QUEUE_LIMIT:   cfg_ql_ff <= pwdata[10:0];
            REG_FAILURE_EN:    cfg_fe_ff <= pwdata[0];
            REG_ARRIVAL_QUOTA: cfg_aq_ff <= pwdata[12:0];
            REG_WARMUP_COUNT:  cfg_wu_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_SERVER_COUNT:  prdata = 32'(cfg_sc_ff);
         REG_QUEUE_LIMIT:   prdata = 32'(cfg_ql_ff);
         REG_FAILURE_EN:    prdata = 32'(cfg_fe_ff);
         REG_ARRIVAL_QUOTA: prdata = 32'(cfg_aq_ff);
         REG_WARMUP_COUNT:  prdata = 32'(cfg_wu_ff);
         default:           prdata = 32'd0;
      endcase
   end

   // effective limits after clamping
   logic [31:0] used32, lim32, quota32;
   always_comb begin
      if (cfg_sc_ff == 4'd0)                    used32 = 32'd1;
      else if (32'(cfg_sc_ff) > MAX_SERVERS)    used32 = 32'(MAX_SERVERS);
      else                                      used32 = 32'(cfg_sc_ff);
      lim32   = (32'(cfg_ql_ff) < QUEUE_DEPTH) ? 32'(cfg_ql_ff) : 32'(QUEUE_DEPTH);
      quota32 = (32'(cfg_aq_ff) < CUSTOMERS) ? 32'(cfg_aq_ff) : 32'(CUSTOMERS);
   end

   // simulation state
   srv_type     srv_state_ff [MAX_SERVERS];
   srv_type     srv_state_in [MAX_SERVERS];
   logic [11:0] srv_cust_ff  [MAX_SERVERS];
   logic [11:0] srv_cust_in  [MAX_SERVERS];
   logic [QAW-1:0] head_ff, head_in;
   logic [QCW-1:0] qcount_ff, qcount_in;
   logic [12:0] emitted_ff, emitted_in;
   logic [12:0] occ_ff, occ_in;
   logic [10:0] queued_ff, queued_in;
   logic [3:0]  busy_ff, busy_in;
   logic [3:0]  down_ff, down_in;
   logic [12:0] dep_ff, dep_in;
   logic [12:0] drop_ff, drop_in;
   logic [12:0] meas_ff, meas_in;
   logic [47:0] last_time_ff, last_time_in;
   logic [63:0] area_ff [4];
   logic [63:0] area_in [4];
   logic [63:0] wait_ff, wait_in;
   logic [63:0] soj_ff, soj_in;

   // control
   fsm_type st_ff, st_in;
   req_type cur_ff;
   logic    req_accept, rsp_accept, go, exec_fire;
   logic [1:0] ob_cnt_ff;
   rsp_type ob_ff [2];

   assign go         = (ob_cnt_ff == 2'd0);
   assign req_stall  = !((st_ff == ST_IDLE) || (st_ff == ST_EXEC && go));
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = (ob_cnt_ff != 2'd0);
   assign rsp_data   = ob_ff[0];
   assign rsp_accept = rsp_valid & ~rsp_stall;
   assign exec_fire  = (st_ff == ST_EXEC) && go;

   always_comb begin
      case (st_ff)
         ST_IDLE: st_in = req_accept ? ST_RD : ST_IDLE;
         ST_RD:   st_in = ST_EXEC;
         ST_EXEC: begin
            if (!go)             st_in = ST_EXEC;
            else if (req_accept) st_in = ST_RD;
            else                 st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept) cur_ff <= req_data;
   end

   // read stage: clamp time, area products, event check, idle server search
   logic [SW-1:0] sidx;
   logic [47:0]   now_rd, dt_rd;
   logic          ok_rd, found_rd;
   logic [SW-1:0] idle_rd;
   logic [47:0]   now_ff;
   logic [60:0]   prod_ff [4];
   logic          ok_ff, found_ff;
   logic [SW-1:0] idle_ff;

   assign sidx   = cur_ff.tag[SW-1:0];
   assign now_rd = (cur_ff.event_time < last_time_ff) ? last_time_ff : cur_ff.event_time;
   assign dt_rd  = now_rd - last_time_ff;

   always_comb begin
      case (cur_ff.op)
         OP_ARRIVE: ok_rd = (32'(cur_ff.tag) < CUSTOMERS);
         OP_DEPART,
         OP_FAIL:   ok_rd = (32'(cur_ff.tag) < MAX_SERVERS) && (srv_state_ff[sidx] == SRV_BUSY);
         OP_REPAIR: ok_rd = (32'(cur_ff.tag) < MAX_SERVERS) && (srv_state_ff[sidx] == SRV_DOWN);
         OP_REPORT: ok_rd = 1'b1;
         default:   ok_rd = 1'b0;
      endcase
      // lowest idle index wins
      found_rd = 1'b0;
      idle_rd  = '0;
      for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
         if (32'(i) < used32 && srv_state_ff[i] == SRV_IDLE) begin
            found_rd = 1'b1;
            idle_rd  = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_RD) begin
         now_ff     <= now_rd;
         prod_ff[0] <= 61'(dt_rd * occ_ff);
         prod_ff[1] <= 61'(dt_rd * queued_ff);
         prod_ff[2] <= 61'(dt_rd * busy_ff);
         prod_ff[3] <= 61'(dt_rd * down_ff);
         ok_ff      <= ok_rd;
         found_ff   <= found_rd;
         idle_ff    <= idle_rd;
      end
   end

   // memories: wait queue and per-customer stamps
   logic [11:0] wq_mem  [QSLOTS];
   logic [47:0] arr_mem [CUSTOMERS];
   logic [47:0] beg_mem [CUSTOMERS];
   logic [11:0] wq_rd_ff;
   logic [47:0] arr_rd_ff, beg_rd_ff;
   logic [CAW-1:0] stamp_raddr;
   logic           wq_we, arr_we, beg_we;
   logic [QAW-1:0] wq_waddr;
   logic [11:0]    wq_wdata;
   logic [CAW-1:0] arr_waddr, beg_waddr;

   assign stamp_raddr = caddr(srv_cust_ff[sidx]);

   always_ff @(posedge clock) begin
      wq_rd_ff  <= wq_mem[head_ff];
      arr_rd_ff <= arr_mem[stamp_raddr];
      beg_rd_ff <= beg_mem[stamp_raddr];
      if (wq_we)  wq_mem[wq_waddr]   <= wq_wdata;
      if (arr_we) arr_mem[arr_waddr] <= now_ff;
      if (beg_we) beg_mem[beg_waddr] <= now_ff;
   end

   // execute stage
   rsp_type     res [2];
   logic [1:0]  n_res;
   logic        do_start;
   logic [SW-1:0] start_srv;
   logic [11:0] start_cust;
   logic [11:0] dep_id;
   logic [31:0] tail32;
   logic [62:0] stat_v;

   always_comb begin
      case (cur_ff.tag)
         STAT_DEPARTURES: stat_v = 63'(dep_ff);
         STAT_HORIZON:    stat_v = 63'(last_time_ff);
         STAT_AREA_SYS:   stat_v = area_ff[0][62:0];
         STAT_AREA_QUEUE: stat_v = area_ff[1][62:0];
         STAT_AREA_BUSY:  stat_v = area_ff[2][62:0];
         STAT_AREA_DOWN:  stat_v = area_ff[3][62:0];
         STAT_WAIT:       stat_v = wait_ff[62:0];
         STAT_SOJOURN:    stat_v = soj_ff[62:0];
         STAT_MEASURED:   stat_v = 63'(meas_ff);
         STAT_DROPS:      stat_v = 63'(drop_ff);
         STAT_EMITTED:    stat_v = 63'(emitted_ff);
         STAT_OCCUPANCY:  stat_v = 63'(occ_ff);
         STAT_QUEUED:     stat_v = 63'(queued_ff);
         STAT_BUSY:       stat_v = 63'(busy_ff);
         STAT_DOWN:       stat_v = 63'(down_ff);
         default:         stat_v = 63'd0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
         srv_state_in[i] = srv_state_ff[i];
         srv_cust_in[i]  = srv_cust_ff[i];
      end
      head_in      = head_ff;
      qcount_in    = qcount_ff;
      emitted_in   = emitted_ff;
      occ_in       = occ_ff;
      queued_in    = queued_ff;
      busy_in      = busy_ff;
      down_in      = down_ff;
      dep_in       = dep_ff;
      drop_in      = drop_ff;
      meas_in      = meas_ff;
      last_time_in = last_time_ff;
      for (int i = 0; i < 4; i++) area_in[i] = area_ff[i];
      wait_in      = wait_ff;
      soj_in       = soj_ff;
      res[0]       = '0;
      res[1]       = '0;
      n_res        = 2'd0;
      do_start     = 1'b0;
      start_srv    = sidx;
      start_cust   = wq_rd_ff;
      wq_we        = 1'b0;
      wq_waddr     = head_ff;
      wq_wdata     = cur_ff.tag;
      arr_we       = 1'b0;
      arr_waddr    = caddr(cur_ff.tag);
      beg_we       = 1'b0;
      beg_waddr    = caddr(start_cust);
      dep_id       = srv_cust_ff[sidx];
      tail32       = 32'(head_ff) + 32'(qcount_ff);
      if (tail32 >= QSLOTS) tail32 = tail32 - 32'(QSLOTS);

      if (exec_fire && ok_ff) begin
         if (cur_ff.op != OP_REPORT) begin
            // time-weighted areas up to now
            for (int i = 0; i < 4; i++) area_in[i] = sat_add(area_ff[i], 64'(prod_ff[i]));
            last_time_in = now_ff;
         end
         case (cur_ff.op)
            OP_ARRIVE: begin
               arr_we = 1'b1;
               if (32'(emitted_ff) < quota32) begin
                  res[0] = put(KIND_ARRIVE, 63'(now_ff) + 63'(cur_ff.gap_time),
                               emitted_ff[11:0]);
                  n_res      = 2'd1;
                  emitted_in = emitted_ff + 13'd1;
               end
               if (found_ff) begin
                  if (occ_ff != 13'h1FFF) occ_in = occ_ff + 13'd1;
                  do_start   = 1'b1;
                  start_srv  = idle_ff;
                  start_cust = cur_ff.tag;
               end else if (32'(qcount_ff) < lim32) begin
                  if (occ_ff != 13'h1FFF)    occ_in    = occ_ff + 13'd1;
                  if (queued_ff != 11'h7FF)  queued_in = queued_ff + 11'd1;
                  wq_we     = 1'b1;
                  wq_waddr  = tail32[QAW-1:0];
                  qcount_in = qcount_ff + QCW'(1);
               end else begin
                  if (drop_ff != 13'h1FFF) drop_in = drop_ff + 13'd1;
               end
            end
            OP_DEPART: begin
               if (occ_ff != 13'd0)     occ_in = occ_ff - 13'd1;
               if (dep_ff != 13'h1FFF)  dep_in = dep_ff + 13'd1;
               if (13'(dep_id) >= cfg_wu_ff) begin
                  wait_in = sat_add(wait_ff,
                     (beg_rd_ff > arr_rd_ff) ? 64'(beg_rd_ff - arr_rd_ff) : 64'd0);
                  soj_in  = sat_add(soj_ff,
                     (now_ff > arr_rd_ff) ? 64'(now_ff - arr_rd_ff) : 64'd0);
                  if (meas_ff != 13'h1FFF) meas_in = meas_ff + 13'd1;
               end
               srv_state_in[sidx] = SRV_IDLE;
               if (busy_ff != 4'd0) busy_in = busy_ff - 4'd1;
               if (qcount_ff != '0) do_start = 1'b1;
            end
            OP_FAIL: begin
               srv_state_in[sidx] = SRV_DOWN;
               if (busy_ff != 4'd0)  busy_in = busy_ff - 4'd1;
               if (down_ff != 4'hF)  down_in = down_ff + 4'd1;
               if (32'(qcount_ff) < QSLOTS) begin
                  // preempted customer goes back to the head
                  head_in   = (head_ff == '0) ? QAW'(QSLOTS - 1) : head_ff - QAW'(1);
                  wq_we     = 1'b1;
                  wq_waddr  = head_in;
                  wq_wdata  = dep_id;
                  qcount_in = qcount_ff + QCW'(1);
                  if (queued_ff != 11'h7FF) queued_in = queued_ff + 11'd1;
               end else begin
                  if (occ_ff != 13'd0)     occ_in  = occ_ff - 13'd1;
                  if (drop_ff != 13'h1FFF) drop_in = drop_ff + 13'd1;
               end
               res[0] = put(KIND_REPAIR, 63'(now_ff) + 63'(cur_ff.repair_time),
                            cur_ff.tag);
               n_res  = 2'd1;
            end
            OP_REPAIR: begin
               srv_state_in[sidx] = SRV_IDLE;
               if (down_ff != 4'd0) down_in = down_ff - 4'd1;
               if (qcount_ff != '0) do_start = 1'b1;
            end
            OP_REPORT: begin
               res[0] = put(KIND_STAT, stat_v, cur_ff.tag);
               n_res  = 2'd1;
            end
            default: ;
         endcase

         if (do_start) begin
            if (cur_ff.op != OP_ARRIVE) begin
               // pop the head of the queue
               head_in   = (32'(head_ff) + 32'd1 >= QSLOTS) ? '0 : head_ff + QAW'(1);
               qcount_in = qcount_ff - QCW'(1);
               if (queued_in != 11'd0) queued_in = queued_in - 11'd1;
            end
            srv_state_in[start_srv] = SRV_BUSY;
            srv_cust_in[start_srv]  = start_cust;
            if (busy_in != 4'hF) busy_in = busy_in + 4'd1;
            beg_we    = 1'b1;
            beg_waddr = caddr(start_cust);
            if (cfg_fe_ff && cur_ff.failure_time < cur_ff.service_time)
               res[n_res[0]] = put(KIND_FAIL, 63'(now_ff) + 63'(cur_ff.failure_time),
                                   12'(start_srv));
            else
               res[n_res[0]] = put(KIND_DEPART, 63'(now_ff) + 63'(cur_ff.service_time),
                                   12'(start_srv));
            n_res = n_res + 2'd1;
         end
         if (n_res != 2'd0) res[n_res[1] ? 1 : 0].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            srv_state_ff[i] <= SRV_IDLE;
            srv_cust_ff[i]  <= 12'd0;
         end
         head_ff      <= '0;
         qcount_ff    <= '0;
         emitted_ff   <= 13'd1;
         occ_ff       <= 13'd0;
         queued_ff    <= 11'd0;
         busy_ff      <= 4'd0;
         down_ff      <= 4'd0;
         dep_ff       <= 13'd0;
         drop_ff      <= 13'd0;
         meas_ff      <= 13'd0;
         last_time_ff <= 48'd0;
         for (int i = 0; i < 4; i++) area_ff[i] <= 64'd0;
         wait_ff      <= 64'd0;
         soj_ff       <= 64'd0;
      end else begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            srv_state_ff[i] <= srv_state_in[i];
            srv_cust_ff[i]  <= srv_cust_in[i];
         end
         head_ff      <= head_in;
         qcount_ff    <= qcount_in;
         emitted_ff   <= emitted_in;
         occ_ff       <= occ_in;
         queued_ff    <= queued_in;
         busy_ff      <= busy_in;
         down_ff      <= down_in;
         dep_ff       <= dep_in;
         drop_ff      <= drop_in;
         meas_ff      <= meas_in;
         last_time_ff <= last_time_in;
         for (int i = 0; i < 4; i++) area_ff[i] <= area_in[i];
         wait_ff      <= wait_in;
         soj_ff       <= soj_in;
      end
   end

   // two-entry result buffer, drains front first
   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
      end else if (exec_fire) begin
         ob_cnt_ff <= n_res;
      end else if (rsp_accept) begin
         ob_cnt_ff <= ob_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         ob_ff[0] <= res[0];
         ob_ff[1] <= res[1];
      end else if (rsp_accept) begin
         ob_ff[0] <= ob_ff[1];
      end
   end

endmodule
`default_nettype wire
